FILE: sv/fcr_pkg.sv
// Shared constants, types and command-word tables for the framed command receiver.
`timescale 1ns / 1ps

package fcr_pkg;

   localparam int BUF_DEPTH_DEF = 128;

   localparam logic [7:0] CH_START = 8'h40;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;

   localparam int ON_LEN  = 6;
   localparam int OFF_LEN = 7;

   localparam logic [1:0] CMD_UNKNOWN = 2'd0;
   localparam logic [1:0] CMD_LED_ON  = 2'd1;
   localparam logic [1:0] CMD_LED_OFF = 2'd2;

   localparam int RSP_DATA_W = 16;

   typedef enum logic [2:0] {
      PH_WAIT = 3'b001,
      PH_DATA = 3'b010,
      PH_TAIL = 3'b100
   } phase_type;

   typedef struct packed {
      logic       valid;
      logic [1:0] command;
      logic [7:0] payload_length;
      logic       overflowed;
   } result_type;

   function automatic logic [7:0] word_on_char(input logic [2:0] idx);
      logic [7:0] ch;
      case (idx)
         3'd0:    ch = 8'h4C; // L
         3'd1:    ch = 8'h45; // E
         3'd2:    ch = 8'h44; // D
         3'd3:    ch = 8'h5F; // _
         3'd4:    ch = 8'h4F; // O
         3'd5:    ch = 8'h4E; // N
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic logic [7:0] word_off_char(input logic [2:0] idx);
      logic [7:0] ch;
      case (idx)
         3'd0:    ch = 8'h4C; // L
         3'd1:    ch = 8'h45; // E
         3'd2:    ch = 8'h44; // D
         3'd3:    ch = 8'h5F; // _
         3'd4:    ch = 8'h4F; // O
         3'd5:    ch = 8'h46; // F
         3'd6:    ch = 8'h46; // F
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

FILE: sv/fcr_frame_tracker.sv
// Frame state machine with per-byte command match tracking.
`timescale 1ns / 1ps

module fcr_frame_tracker #(
   parameter int BUF_DEPTH = fcr_pkg::BUF_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               byte_accept,
   input  logic [7:0]         rx_byte,
   output fcr_pkg::result_type result
);

   localparam int CNT_W = $clog2(BUF_DEPTH + 1);

   fcr_pkg::phase_type phase_ff, phase_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic               overflow_ff, overflow_in;
   logic               on_ok_ff, on_ok_in;
   logic               off_ok_ff, off_ok_in;
   logic               zero_seen_ff, zero_seen_in;

   logic               pos_on;
   logic               pos_off;
   logic               len_on;
   logic               len_off;
   logic [2:0]         pos_idx;

   assign pos_idx = fill_ff[2:0];
   assign pos_on  = 32'(fill_ff) < fcr_pkg::ON_LEN;
   assign pos_off = 32'(fill_ff) < fcr_pkg::OFF_LEN;
   assign len_on  = 32'(fill_ff) == fcr_pkg::ON_LEN;
   assign len_off = 32'(fill_ff) == fcr_pkg::OFF_LEN;

   always_comb begin
      phase_in       = phase_ff;
      fill_in        = fill_ff;
      overflow_in    = overflow_ff;
      on_ok_in       = on_ok_ff;
      off_ok_in      = off_ok_ff;
      zero_seen_in   = zero_seen_ff;
      result         = '0;
      result.command = fcr_pkg::CMD_UNKNOWN;

      if (byte_accept) begin
         case (phase_ff)
            fcr_pkg::PH_DATA: begin
               if (rx_byte == fcr_pkg::CH_CR) begin
                  phase_in = fcr_pkg::PH_TAIL;
               end else if (32'(fill_ff) < BUF_DEPTH) begin
                  fill_in = fill_ff + CNT_W'(1);
                  // text ends at the first zero byte; later bytes leave the match alone
                  if (!zero_seen_ff) begin
                     if (rx_byte == 8'h00) begin
                        zero_seen_in = 1'b1;
                        on_ok_in     = on_ok_ff & len_on;
                        off_ok_in    = off_ok_ff & len_off;
                     end else begin
                        on_ok_in  = on_ok_ff & pos_on &
                                    (rx_byte == fcr_pkg::word_on_char(pos_idx));
                        off_ok_in = off_ok_ff & pos_off &
                                    (rx_byte == fcr_pkg::word_off_char(pos_idx));
                     end
                  end
               end else begin
                  overflow_in = 1'b1;
               end
            end
            fcr_pkg::PH_TAIL: begin
               if (rx_byte == fcr_pkg::CH_LF) begin
                  phase_in     = fcr_pkg::PH_WAIT;
                  result.valid = 1'b1;
                  if (on_ok_ff && (zero_seen_ff || len_on)) begin
                     result.command = fcr_pkg::CMD_LED_ON;
                  end else if (off_ok_ff && (zero_seen_ff || len_off)) begin
                     result.command = fcr_pkg::CMD_LED_OFF;
                  end
                  result.payload_length = (32'(fill_ff) > 255) ? 8'hFF : 8'(fill_ff);
                  result.overflowed     = overflow_ff;
               end
            end
            default: begin
               phase_in = fcr_pkg::PH_WAIT;
               if (rx_byte == fcr_pkg::CH_START) begin
                  phase_in     = fcr_pkg::PH_DATA;
                  fill_in      = '0;
                  overflow_in  = 1'b0;
                  on_ok_in     = 1'b1;
                  off_ok_in    = 1'b1;
                  zero_seen_in = 1'b0;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= fcr_pkg::PH_WAIT;
         fill_ff      <= '0;
         overflow_ff  <= 1'b0;
         on_ok_ff     <= 1'b0;
         off_ok_ff    <= 1'b0;
         zero_seen_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         fill_ff      <= fill_in;
         overflow_ff  <= overflow_in;
         on_ok_ff     <= on_ok_in;
         off_ok_ff    <= off_ok_in;
         zero_seen_ff <= zero_seen_in;
      end
   end

endmodule

FILE: sv/fcr_result_reg.sv
// Output register for result words with stream handshake.
`timescale 1ns / 1ps

module fcr_result_reg (
   input  logic                              clock,
   input  logic                              reset,
   input  fcr_pkg::result_type               result,
   output logic                              free,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [fcr_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   logic       valid_ff, valid_in;
   logic [1:0] command_ff, command_in;
   logic [7:0] length_ff, length_in;
   logic       overflow_ff, overflow_in;

   // the register can take a new word when empty or when its word leaves now
   assign free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in    = valid_ff;
      command_in  = command_ff;
      length_in   = length_ff;
      overflow_in = overflow_ff;
      if (free) begin
         valid_in    = result.valid;
         command_in  = result.command;
         length_in   = result.payload_length;
         overflow_in = result.overflowed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      command_ff  <= command_in;
      length_ff   <= length_in;
      overflow_ff <= overflow_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {5'b0, overflow_ff, length_ff, command_ff};

endmodule

FILE: sv/framed_command_receiver.sv
// Top level: receives '@'-framed command bytes and reports command, length and overflow.
//
//   channel   dir   width  fields (low bit first)
//   req       in    8      rx_byte[7:0]
//   rsp       out   16     command[1:0], payload_length[9:2], overflowed[10], zero pad
//
// One byte is taken per cycle while req_tready is high; the frame state updates in the cycle the byte is taken.
// The result of a closing line feed is registered and is visible in rsp in the cycle after that byte is taken.
// req_tready is low only while a result waits in the output register and rsp_tready is low.
// Synchronous active-high reset returns the block to waiting for '@' with no result pending.
`timescale 1ns / 1ps

module framed_command_receiver #(
   parameter int BUF_DEPTH = fcr_pkg::BUF_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,  // rx_byte[7:0]
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [fcr_pkg::RSP_DATA_W-1:0] rsp_tdata   // command[1:0], payload_length[9:2],
                                                      // overflowed[10]
);

   fcr_pkg::result_type result;
   logic                free;

   assign req_tready = free;

   fcr_frame_tracker #(
      .BUF_DEPTH (BUF_DEPTH)
   ) u_tracker (
      .clock       (clock),
      .reset       (reset),
      .byte_accept (req_tvalid && free),
      .rx_byte     (req_tdata),
      .result      (result)
   );

   fcr_result_reg u_result (
      .clock      (clock),
      .reset      (reset),
      .result     (result),
      .free       (free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

FILE: sim/tb_framed_command_receiver.sv
// Self-checking testbench for the framed command receiver: directed and random framed byte streams.
`timescale 1ns / 1ps

module tb_framed_command_receiver;

   localparam int DEPTH        = fcr_pkg::BUF_DEPTH_DEF;
   localparam int ITEM_TARGET  = 1650;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int LONG_STALL   = 600;
   localparam int SETTLE       = 40;
   localparam int MAX_REPORTED = 10;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] length;
      logic       overflowed;
   } report_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;

   // stimulus and expected reports
   logic [7:0] pending_bytes[$];
   report_type expected_reports[$];

   // frame tracker state
   fcr_pkg::phase_type track_phase = fcr_pkg::PH_WAIT;
   int         kept_count = 0;
   logic       drop_seen = 1'b0;
   logic [7:0] kept_bytes[DEPTH];
   string      led_on_text  = "LED_ON";
   string      led_off_text = "LED_OFF";

   // bookkeeping
   int errors = 0;
   int bytes_sent = 0;
   int cycle_count = 0;
   int frames_on = 0, frames_off = 0, frames_unknown = 0, frames_dropped = 0;
   int send_gap = 0, send_calm = 0;
   int recv_hold = 0, recv_calm = 0;
   logic long_hold = 1'b0;
   int long_count = 0, stalls_done = 0;

   framed_command_receiver u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // rx_byte[7:0]
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)    // command[1:0], payload_length[9:2], overflowed[10]
   );

   always #5 clock = ~clock;

   function automatic logic word_matches(input string word, input int text_len);
      logic same;
      same = (text_len == word.len());
      for (int k = 0; k < word.len() && same; k++) begin
         if (kept_bytes[k] != word[k]) same = 1'b0;
      end
      return same;
   endfunction

   // Advance the frame tracker by one accepted word; queue a report on the closing line feed.
   task automatic track_byte(input logic [7:0] b);
      int         text_len;
      report_type want;
      case (track_phase)
         fcr_pkg::PH_DATA: begin
            if (b == fcr_pkg::CH_CR) begin
               track_phase = fcr_pkg::PH_TAIL;
            end else if (kept_count < DEPTH) begin
               kept_bytes[kept_count] = b;
               kept_count++;
            end else begin
               drop_seen = 1'b1;
            end
         end
         fcr_pkg::PH_TAIL: begin
            if (b == fcr_pkg::CH_LF) begin
               // compare stops at the first zero byte
               text_len = kept_count;
               for (int k = kept_count - 1; k >= 0; k--) begin
                  if (kept_bytes[k] == 8'h00) text_len = k;
               end
               if (word_matches(led_on_text, text_len)) begin
                  want.command = fcr_pkg::CMD_LED_ON;
                  frames_on++;
               end else if (word_matches(led_off_text, text_len)) begin
                  want.command = fcr_pkg::CMD_LED_OFF;
                  frames_off++;
               end else begin
                  want.command = fcr_pkg::CMD_UNKNOWN;
                  frames_unknown++;
               end
               want.length     = (kept_count > 255) ? 8'd255 : kept_count[7:0];
               want.overflowed = drop_seen;
               if (drop_seen) frames_dropped++;
               expected_reports.push_back(want);
               track_phase = fcr_pkg::PH_WAIT;
            end
         end
         default: begin
            track_phase = fcr_pkg::PH_WAIT;
            if (b == fcr_pkg::CH_START) begin
               track_phase = fcr_pkg::PH_DATA;
               kept_count  = 0;
               drop_seen   = 1'b0;
            end
         end
      endcase
   endtask

   task automatic check_report(input logic [15:0] data);
      report_type got, want;
      got.command    = data[1:0];
      got.length     = data[9:2];
      got.overflowed = data[10];
      if (expected_reports.size() == 0) begin
         errors++;
         if (errors <= MAX_REPORTED)
            $display("%0t: unexpected report cmd=%0d len=%0d ovf=%0b", $realtime,
                     got.command, got.length, got.overflowed);
      end else begin
         want = expected_reports.pop_front();
         if (got.command !== want.command || got.length !== want.length ||
             got.overflowed !== want.overflowed) begin
            errors++;
            if (errors <= MAX_REPORTED)
               $display({"%0t: report mismatch exp cmd=%0d len=%0d ovf=%0b, ",
                         "got cmd=%0d len=%0d ovf=%0b"},
                        $realtime, want.command, want.length, want.overflowed,
                        got.command, got.length, got.overflowed);
         end
      end
   endtask

   // Gaps: drawn uniformly at random, with occasional calm stretches of back-to-back words.
   function automatic int draw_send_gap();
      if (send_calm > 0) begin
         send_calm--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) send_calm = $urandom_range(50, 150);
      return $urandom_range(0, 19);
   endfunction

   function automatic int draw_recv_hold();
      if (recv_calm > 0) begin
         recv_calm--;
         return 0;
      end
      if ($urandom_range(0, 9) == 0) recv_calm = $urandom_range(5, 20);
      return $urandom_range(0, 19);
   endfunction

   // ---------------- stimulus ----------------
   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) pending_bytes.push_back(s[i]);
   endtask

   function automatic logic [7:0] payload_byte();
      logic [7:0] b;
      case ($urandom_range(0, 15))
         0:       b = fcr_pkg::CH_START;
         1:       b = fcr_pkg::CH_LF;
         2:       b = 8'h00;
         default: begin
            b = 8'($urandom_range(0, 255));
            if (b == fcr_pkg::CH_CR) b = 8'hFF;
         end
      endcase
      return b;
   endfunction

   function automatic logic [7:0] tail_byte();
      logic [7:0] b;
      case ($urandom_range(0, 7))
         0:       b = fcr_pkg::CH_CR;
         1:       b = fcr_pkg::CH_START;
         default: begin
            b = 8'($urandom_range(0, 255));
            if (b == fcr_pkg::CH_LF) b = 8'hF5;
         end
      endcase
      return b;
   endfunction

   task automatic push_random_payload(input int count);
      repeat (count) pending_bytes.push_back(payload_byte());
   endtask

   task automatic add_random_frame();
      string      word;
      int         cut;
      logic [7:0] b;
      // stray bytes between frames, any value
      if ($urandom_range(0, 4) == 0) begin
         repeat ($urandom_range(1, 3)) begin
            b = 8'($urandom_range(0, 255));
            pending_bytes.push_back(b);
         end
      end
      pending_bytes.push_back(fcr_pkg::CH_START);
      word = $urandom_range(0, 1) ? led_on_text : led_off_text;
      case ($urandom_range(0, 9))
         0, 1: push_text(word);
         2: begin
            push_text(word);
            pending_bytes.push_back(8'h00);
            push_random_payload($urandom_range(0, 4));
         end
         3: begin
            // near miss: one character replaced
            cut = $urandom_range(0, word.len() - 1);
            for (int i = 0; i < word.len(); i++) begin
               if (i == cut) pending_bytes.push_back(payload_byte());
               else pending_bytes.push_back(word[i]);
            end
         end
         4: begin
            cut = $urandom_range(0, led_off_text.len() - 1);
            for (int i = 0; i < cut; i++) pending_bytes.push_back(led_off_text[i]);
         end
         5: begin
            push_text(word);
            b = payload_byte();
            if (b == 8'h00) b = 8'h21;
            pending_bytes.push_back(b);
         end
         9: push_random_payload(($urandom_range(0, 2) == 0)
                                ? $urandom_range(DEPTH - 8, DEPTH + 12)
                                : $urandom_range(0, 20));
         default: push_random_payload($urandom_range(0, 20));
      endcase
      // rarely leave the frame open and let the next bytes fall where they may
      if ($urandom_range(0, 19) == 0) return;
      pending_bytes.push_back(fcr_pkg::CH_CR);
      repeat ($urandom_range(0, 2)) pending_bytes.push_back(tail_byte());
      if ($urandom_range(0, 24) != 0) pending_bytes.push_back(fcr_pkg::CH_LF);
   endtask

   task automatic build_stimulus();
      // noise before start, LED_ON
      push_text("q@LED_ON");
      pending_bytes.push_back(fcr_pkg::CH_CR);
      pending_bytes.push_back(fcr_pkg::CH_LF);
      // LED_OFF with a second carriage return and junk in the tail
      push_text("@LED_OFF");
      pending_bytes.push_back(fcr_pkg::CH_CR);
      pending_bytes.push_back(fcr_pkg::CH_CR);
      push_text("5");
      pending_bytes.push_back(fcr_pkg::CH_LF);
      // empty payload
      pending_bytes.push_back(fcr_pkg::CH_START);
      pending_bytes.push_back(fcr_pkg::CH_CR);
      pending_bytes.push_back(fcr_pkg::CH_LF);
      while (pending_bytes.size() < ITEM_TARGET) add_random_frame();
      // close a frame left open so that it too ends on a report
      pending_bytes.push_back(fcr_pkg::CH_CR);
      pending_bytes.push_back(fcr_pkg::CH_LF);
   endtask

   // ---------------- driver ----------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            track_byte(req_tdata);
            bytes_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_bytes.size() > 0) begin
               req_tdata  <= pending_bytes.pop_front();
               req_tvalid <= 1'b1;
               send_gap = draw_send_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------- monitor ----------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_hold = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_report(rsp_tdata);
            recv_hold = draw_recv_hold();
         end else if (recv_hold > 0) begin
            recv_hold--;
         end
         rsp_tready <= (recv_hold == 0) && !long_hold;
      end
   end

   // Hold off the receiver for a long stretch so the output word backs up into the input.
   always @(posedge clock) begin
      if (reset) begin
         long_hold <= 1'b0;
         long_count = 0;
      end else if (long_hold) begin
         long_count++;
         if (long_count >= LONG_STALL) begin
            long_hold <= 1'b0;
            stalls_done++;
         end
      end else if (stalls_done < 2 && bytes_sent >= 400 + 700 * stalls_done) begin
         long_hold <= 1'b1;
         long_count = 0;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d bytes sent, %0d reports outstanding",
                  cycle_count, bytes_sent, expected_reports.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      build_stimulus();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      while (pending_bytes.size() > 0 || req_tvalid) @(posedge clock);
      while (expected_reports.size() > 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      $display("Sent %0d bytes; checked %0d frames: %0d LED_ON, %0d LED_OFF, %0d unknown",
               bytes_sent, frames_on + frames_off + frames_unknown, frames_on, frames_off,
               frames_unknown);
      $display("%0d frames dropped payload bytes; %0d long receiver stalls; %0d mismatches",
               frames_dropped, stalls_done, errors);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
